>>> rtl/core/isort_pkg.sv
// Shared types, constants and the comparator for the insertion sorter.
// Used by isort_cell and insertion_sorter_unit; depends on nothing.
`default_nettype none

package isort_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;

  localparam logic ORDER_ASCENDING  = 1'b0;
  localparam logic ORDER_DESCENDING = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;
  } out_item_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     valid;
    logic                     shift;
  } cell_link_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic                     insert;
    logic                     drain;
    logic                     order;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

  // True when a strictly precedes b under the given order.
  function automatic logic precedes(input logic order,
                                    input logic signed [DATA_W-1:0] a,
                                    input logic signed [DATA_W-1:0] b);
    logic result;
    if (order == ORDER_DESCENDING) begin
      result = (a > b);
    end else begin
      result = (a < b);
    end
    return result;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/isort_cell.sv
// One slot of the insertion chain: holds one element and its occupied bit.
// Depends on isort_pkg for the link and control types and the comparator.
`default_nettype none

module isort_cell (
  input  wire                     clk,
  input  wire                     rst,
  input  isort_pkg::cell_ctrl_t   ctrl,
  input  isort_pkg::cell_link_t   prev,
  input  isort_pkg::cell_link_t   next,
  output isort_pkg::cell_link_t   link
);

  logic signed [isort_pkg::DATA_W-1:0] held;
  logic                                occupied;
  logic                                shift;
  logic                                take;

  // Push the held element one slot right when the new one goes in front of it.
  assign shift = ctrl.insert && occupied && isort_pkg::precedes(ctrl.order, ctrl.value, held);
  // Take an element when shifting, or when this is the first free slot.
  assign take  = shift || (!occupied && prev.valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else if (ctrl.insert && take) begin
      occupied <= 1'b1;
    end else if (ctrl.drain) begin
      occupied <= next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && take) begin
      held <= prev.shift ? prev.value : ctrl.value;
    end else if (ctrl.drain) begin
      held <= next.value;
    end
  end

  assign link.value = held;
  assign link.valid = occupied;
  assign link.shift = shift;

endmodule

`default_nettype wire

>>> rtl/core/insertion_sorter_unit.sv
// Top level of the insertion sorter: a chain of isort_cell slots plus the
// fill/drain control and the sort_order register. Depends on isort_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall/in_item) takes one signed element per
//   item; in_item.last_in marks the final element of a list. Each accepted
//   element is registered directly into its slot in the chain, so a list is
//   loaded at one element per cycle. Elements that arrive while all 64 slots
//   are full are dropped and the list is marked as overflowed.
//   After the final element is accepted the chain drains toward slot 0:
//   output channel (out_valid/out_stall/out_item) carries the sorted list,
//   one item per cycle while out_stall is low, the first one in the cycle
//   after the last element went in. last_out flags the final item, overflow
//   is set on every item of an overflowed list. While draining, in_stall is
//   high, so no new list is taken until the current one has fully drained.
//   A stall on the output holds the head item and freezes the chain.
//   cfg_we/cfg_data write sort_order (0 ascending, 1 descending); write it
//   only while idle. Equal elements keep their arrival order.
//   Reset (rst, synchronous) empties the chain, clears overflow and sets
//   ascending order; the block is ready in the next cycle.
`default_nettype none

module insertion_sorter_unit (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  isort_pkg::in_item_t    in_item,
  output logic                   out_valid,
  input  wire                    out_stall,
  output isort_pkg::out_item_t   out_item,
  input  wire                    cfg_we,
  input  wire                    cfg_data
);

  isort_pkg::cell_link_t links [isort_pkg::CAPACITY];
  isort_pkg::cell_ctrl_t ctrl;
  isort_pkg::cell_link_t edge_head;
  isort_pkg::cell_link_t edge_tail;

  logic sort_order;
  logic draining;
  logic dropped;
  logic in_take;
  logic full;
  logic out_take;
  logic head_last;

  assign full      = links[isort_pkg::CAPACITY-1].valid;
  assign in_stall  = draining;
  assign in_take   = in_valid && !in_stall;
  assign head_last = !links[1].valid;
  assign out_valid = draining;
  assign out_take  = out_valid && !out_stall;

  assign ctrl.insert = in_take && !full;
  assign ctrl.drain  = out_take;
  assign ctrl.order  = sort_order;
  assign ctrl.value  = in_item.value;

  // Slot 0 always sees an occupied left neighbor that never shifts.
  assign edge_head.value = '0;
  assign edge_head.valid = 1'b1;
  assign edge_head.shift = 1'b0;
  assign edge_tail.value = '0;
  assign edge_tail.valid = 1'b0;
  assign edge_tail.shift = 1'b0;

  for (genvar i = 0; i < isort_pkg::CAPACITY; i++) begin : g_cell
    isort_pkg::cell_link_t prev_link;
    isort_pkg::cell_link_t next_link;
    if (i == 0) begin : g_first
      assign prev_link = edge_head;
    end else begin : g_mid_prev
      assign prev_link = links[i-1];
    end
    if (i == isort_pkg::CAPACITY-1) begin : g_last
      assign next_link = edge_tail;
    end else begin : g_mid_next
      assign next_link = links[i+1];
    end
    isort_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .prev (prev_link),
      .next (next_link),
      .link (links[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_order <= isort_pkg::ORDER_ASCENDING;
    end else if (cfg_we) begin
      sort_order <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else begin
      if (in_take && full) begin
        dropped <= 1'b1;
      end
      if (in_take && in_item.last_in) begin
        draining <= 1'b1;
      end
      // End of list: leave drain mode and forget the overflow.
      if (out_take && head_last) begin
        draining <= 1'b0;
        dropped  <= 1'b0;
      end
    end
  end

  assign out_item.sorted_value = links[0].value;
  assign out_item.last_out     = head_last;
  assign out_item.overflow     = dropped;

endmodule

`default_nettype wire
